### src/fhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhp_pkg
// Types, constants and the fire palette for the fire heat propagation unit.
// ----------------------------------------------------------------------------
package fhp_pkg;

	localparam int DEF_WIDTH  = 240;
	localparam int DEF_HEIGHT = 240;

	localparam logic [7:0] COOLING_RESET = 8'd5;

	// apb register map
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_COOLING = 1'b0;

	// item opcodes
	localparam logic OP_SEED   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// four neighbour bytes summed; ACC_MAX bounds the partial sum of three
	localparam int ACC_W = 10;
	localparam logic [ACC_W-1:0] ACC_MAX = 10'd765;

	// palette band edges
	localparam logic [7:0] BAND_RED    = 8'd64;
	localparam logic [7:0] BAND_YELLOW = 8'd128;
	localparam logic [7:0] BAND_WHITE  = 8'd192;

	typedef struct packed {
		logic       opcode;
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] seed_near;
		logic [7:0] seed_far;
	} fhp_item_t;

	typedef struct packed {
		logic [7:0]  display_row;
		logic [7:0]  display_column;
		logic [7:0]  heat;
		logic [15:0] pixel_color;
	} fhp_result_t;

	// black, red, yellow, white ramp packed as rgb565
	function automatic logic [15:0] fire_color(input logic [7:0] h);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		begin
			r = 8'hFF;
			g = 8'hFF;
			b = 8'hFF;
			if (h < BAND_RED) begin
				r = {h[5:0], 2'b00};
				g = 8'h00;
				b = 8'h00;
			end else if (h < BAND_YELLOW) begin
				g = {h[5:0], 2'b00};
				b = 8'h00;
			end else if (h < BAND_WHITE) begin
				b = {h[5:0], 2'b00};
			end
			return {r[7:3], g[7:2], b[7:3]};
		end
	endfunction

endpackage
`default_nettype wire

### src/fire_heat_propagation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_heat_propagation_unit
// Heat grid of a fire effect: seeds source columns and updates cells in place.
// ----------------------------------------------------------------------------
// Usage:
//   item / item_valid / item_stall carries seed and update items; an update
//   yields one item on result / result_valid / result_stall, a seed yields
//   none, and an update or seed outside the grid is dropped.
//   cooling must be written over apb while the unit is idle; not enforced.
// Timing:
//   every seed or update occupies the sequencer through all its phases: the
//   four neighbour reads of an update share the single read port of the heat
//   memory. An update passes the sequencer and the finishing update, which
//   loads the result register behind result_valid. An accepted item waits in
//   an input register while the previous one is still running.
// Reset:
//   after arst_n all (HEIGHT+2)*WIDTH cells of the heat memory (58080 by
//   default) are cleared one cell per cycle; item_stall is high meanwhile.
// Stall:
//   a held result keeps its register; the next update then waits before its
//   first read, and the input register fills and raises item_stall.
// ----------------------------------------------------------------------------
module fire_heat_propagation_unit #(
	parameter int WIDTH  = fhp_pkg::DEF_WIDTH,
	parameter int HEIGHT = fhp_pkg::DEF_HEIGHT
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_stall,
	input  fhp_pkg::fhp_item_t        item,
	output logic                      result_valid,
	input  wire                       result_stall,
	output fhp_pkg::fhp_result_t      result,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [fhp_pkg::PADDR_W-1:0] paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import fhp_pkg::*;

	localparam int DEPTH = (HEIGHT + 2) * WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int COL_W = $clog2(WIDTH);

	// configuration
	logic [7:0]           cooling_q;
	logic [REG_IDX_W-1:0] reg_idx;

	// input register
	fhp_item_t in_q;
	logic      in_valid_q;

	// sequencer
	logic             busy_q;
	logic [1:0]       phase_q;
	logic             upd_q;
	logic [AW-1:0]    base1_q;
	logic [AW-1:0]    base2_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] left_q;
	logic [COL_W-1:0] right_q;
	logic [7:0]       near_q;
	logic [7:0]       far_q;
	logic [7:0]       disp_row_q;
	logic [7:0]       disp_col_q;

	// finishing update
	logic          done_pending_q;
	logic [AW-1:0] dn_addr_q;
	logic [7:0]    dn_row_q;
	logic [7:0]    dn_col_q;
	logic [ACC_W-1:0] acc_q;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	// memory
	logic [7:0]    heat_mem [DEPTH];
	logic [7:0]    rd_data_s1;
	logic          fwd_hit_s1;
	logic [7:0]    fwd_data_s1;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_row_q;
	logic [7:0]  out_col_q;
	logic [7:0]  out_heat_q;

	logic             out_free;
	logic             adv;
	logic             seq_free;
	logic             take;
	logic             item_ok;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             seed_we;
	logic             done_fire;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic [7:0]       rd_word;
	logic [ACC_W-1:0] sum;
	logic [7:0]       avg;
	logic [7:0]       new_heat;
	logic [COL_W-1:0] in_col;

	// apb
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign prdata  = (reg_idx == REG_COOLING) ? {24'd0, cooling_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_q <= COOLING_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_COOLING) begin
			cooling_q <= pwdata[7:0];
		end
	end

	// control
	assign out_free  = !out_valid_q || !result_stall;
	assign adv       = !(done_pending_q && !out_free);
	assign done_fire = done_pending_q && out_free;
	assign seq_free  = !busy_q || (phase_q == 2'd3);
	assign take      = seq_free && in_valid_q && !clr_busy_q;
	assign item_stall = clr_busy_q || (in_valid_q && !take);

	assign in_col = COL_W'(in_q.column);
	always_comb begin
		if (in_q.opcode == OP_UPDATE) begin
			item_ok = (32'(in_q.row) < HEIGHT) && (32'(in_q.column) < WIDTH);
		end else begin
			item_ok = 32'(in_q.column) < WIDTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (item_valid && !item_stall) begin
			in_valid_q <= 1'b1;
		end else if (take) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			in_q <= item;
		end
	end

	// sequencer: phases 0..3 issue the four neighbour reads; phases 1 and 2 the seed writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			phase_q        <= 2'd0;
			done_pending_q <= 1'b0;
		end else begin
			if (done_fire) begin
				done_pending_q <= 1'b0;
			end
			if (busy_q && adv) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
					if (upd_q) begin
						done_pending_q <= 1'b1;
					end
				end
			end
			if (take && item_ok) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_ok) begin
			upd_q      <= in_q.opcode == OP_UPDATE;
			col_q      <= in_col;
			left_q     <= (in_col == '0) ? COL_W'(WIDTH - 1) : in_col - COL_W'(1);
			right_q    <= (in_col == COL_W'(WIDTH - 1)) ? '0 : in_col + COL_W'(1);
			near_q     <= in_q.seed_near;
			far_q      <= in_q.seed_far;
			disp_row_q <= 8'(HEIGHT - 1) - in_q.row;
			disp_col_q <= in_q.column;
			if (in_q.opcode == OP_UPDATE) begin
				base1_q <= (AW'(in_q.row) + AW'(1)) * AW'(WIDTH);
				base2_q <= (AW'(in_q.row) + AW'(2)) * AW'(WIDTH);
			end else begin
				base1_q <= AW'(HEIGHT * WIDTH);
				base2_q <= AW'((HEIGHT + 1) * WIDTH);
			end
		end
		if (busy_q && adv && upd_q && phase_q == 2'd3) begin
			dn_addr_q <= base1_q - AW'(WIDTH) + AW'(col_q);
			dn_row_q  <= disp_row_q;
			dn_col_q  <= disp_col_q;
		end
		if (busy_q && adv && upd_q && phase_q != 2'd0) begin
			acc_q <= ((phase_q == 2'd1) ? '0 : acc_q) + ACC_W'(rd_word);
		end
	end

	// read and write ports
	assign rd_en   = busy_q && adv && upd_q;
	assign seed_we = busy_q && adv && !upd_q && (phase_q == 2'd1 || phase_q == 2'd2);

	always_comb begin
		case (phase_q)
			2'd0:    rd_addr = base1_q + AW'(left_q);
			2'd1:    rd_addr = base1_q + AW'(col_q);
			2'd2:    rd_addr = base1_q + AW'(right_q);
			default: rd_addr = base2_q + AW'(col_q);
		endcase
	end

	assign rd_word  = fwd_hit_s1 ? fwd_data_s1 : rd_data_s1;
	assign sum      = acc_q + ACC_W'(rd_word);
	assign avg      = sum[ACC_W-1:2];
	assign new_heat = (avg > cooling_q) ? avg - cooling_q : 8'd0;

	always_comb begin
		mem_we  = 1'b1;
		wr_addr = clr_cnt_q;
		wr_data = 8'd0;
		if (clr_busy_q) begin
			wr_addr = clr_cnt_q;
		end else if (done_fire) begin
			wr_addr = dn_addr_q;
			wr_data = new_heat;
		end else if (seed_we) begin
			wr_addr = (phase_q == 2'd1) ? base1_q + AW'(col_q) : base2_q + AW'(col_q);
			wr_data = (phase_q == 2'd1) ? near_q : far_q;
		end else begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heat_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= heat_mem[rd_addr];
		end
	end

	// a write in the same cycle as a read of that cell is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_s1 <= mem_we && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= wr_data;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_row_q  <= dn_row_q;
			out_col_q  <= dn_col_q;
			out_heat_q <= new_heat;
		end
	end

	assign result_valid          = out_valid_q;
	assign result.display_row    = out_row_q;
	assign result.display_column = out_col_q;
	assign result.heat           = out_heat_q;
	assign result.pixel_color    = fire_color(out_heat_q);

	// checks
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!busy_q && !done_pending_q))
		else $error("item running during clearing pass");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done_pending_q |-> (phase_q == 2'd0))
		else $error("finishing update overlaps a later read phase");

	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_fire && seed_we))
		else $error("update write and seed write collide");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && upd_q && (phase_q == 2'd2 || phase_q == 2'd3)) |-> (acc_q <= ACC_MAX))
		else $error("neighbour sum out of range");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> result_valid)
		else $error("finished update gave no result");

endmodule
`default_nettype wire

### tb/fire_heat_checker.sv
// ----------------------------------------------------------------------------
// fire_heat_checker
// Watches the item, result and apb channels of the fire heat propagation unit,
// keeps its own heat grid and cooling value, predicts every result and
// compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module fire_heat_checker #(
	parameter int WIDTH  = fhp_pkg::DEF_WIDTH,
	parameter int HEIGHT = fhp_pkg::DEF_HEIGHT
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        item_valid,
	input  wire                        item_stall,
	input  fhp_pkg::fhp_item_t         item,
	input  wire                        result_valid,
	input  wire                        result_stall,
	input  fhp_pkg::fhp_result_t       result,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire                        pready,
	input  wire [fhp_pkg::PADDR_W-1:0] paddr,
	input  wire [31:0]                 pwdata,
	output int unsigned                fail_count,
	output int unsigned                pending
);
	import fhp_pkg::*;

	localparam int CELLS = (HEIGHT + 2) * WIDTH;

	logic [7:0] heat_map [0:CELLS-1];
	logic [7:0] cooling;
	fhp_result_t flame_q [$];

	// black, red, yellow, white ramp as rgb565
	function automatic logic [15:0] ramp565(input int unsigned h);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		if (h < 64) begin
			r = h * 4;
			g = 0;
			b = 0;
		end else if (h < 128) begin
			r = 255;
			g = (h - 64) * 4;
			b = 0;
		end else if (h < 192) begin
			r = 255;
			g = 255;
			b = (h - 128) * 4;
		end else begin
			r = 255;
			g = 255;
			b = 255;
		end
		return 16'(((r & 8'hF8) << 8) | ((g & 8'hFC) << 3) | ((b & 8'hFF) >> 3));
	endfunction

	task automatic propagate(input fhp_item_t it);
		int unsigned r;
		int unsigned c;
		int unsigned left;
		int unsigned right;
		int unsigned avg;
		int unsigned h;
		fhp_result_t res;
		r = 32'(it.row);
		c = 32'(it.column);
		if (it.opcode == OP_SEED) begin
			if (c < WIDTH) begin
				heat_map[HEIGHT * WIDTH + c] = it.seed_near;
				heat_map[(HEIGHT + 1) * WIDTH + c] = it.seed_far;
			end
		end else if (r < HEIGHT && c < WIDTH) begin
			left = (c == 0) ? WIDTH - 1 : c - 1;
			right = (c == WIDTH - 1) ? 0 : c + 1;
			avg = (heat_map[(r + 1) * WIDTH + left] + heat_map[(r + 1) * WIDTH + c]
				+ heat_map[(r + 1) * WIDTH + right] + heat_map[(r + 2) * WIDTH + c]) / 4;
			h = (avg > cooling) ? avg - cooling : 0;
			heat_map[r * WIDTH + c] = 8'(h);
			res.display_row = 8'(HEIGHT - 1 - r);
			res.display_column = 8'(c);
			res.heat = 8'(h);
			res.pixel_color = ramp565(h);
			flame_q.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned misses;
		fhp_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) heat_map[i] = 8'd0;
			cooling = COOLING_RESET;
			flame_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			misses = 0;
			if (result_valid && !result_stall) begin
				if (flame_q.size() == 0) begin
					$error("result with no update waiting: display_row %0d display_column %0d",
						result.display_row, result.display_column);
					misses++;
				end else begin
					want = flame_q.pop_front();
					if (result.display_row !== want.display_row) begin
						$error("display_row: expected %0d, got %0d",
							want.display_row, result.display_row);
						misses++;
					end
					if (result.display_column !== want.display_column) begin
						$error("display_column: expected %0d, got %0d",
							want.display_column, result.display_column);
						misses++;
					end
					if (result.heat !== want.heat) begin
						$error("heat: expected %0d, got %0d", want.heat, result.heat);
						misses++;
					end
					if (result.pixel_color !== want.pixel_color) begin
						$error("pixel_color: expected %h, got %h",
							want.pixel_color, result.pixel_color);
						misses++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_COOLING)
				cooling = pwdata[7:0];
			if (item_valid && !item_stall) propagate(item);
			fail_count <= fail_count + misses;
			pending <= flame_q.size();
		end
	end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives seed and update items, cooling writes and result back-pressure into
// the fire heat propagation unit; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import fhp_pkg::*;

	localparam int GRID_W       = DEF_WIDTH;
	localparam int GRID_H       = DEF_HEIGHT;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 155;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 16;
	localparam int IDLE_LIMIT   = 250000;
	localparam logic [PADDR_W-1:0] COOLING_ADDR = {REG_COOLING, 2'b00};

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	fhp_item_t           item;
	logic                result_valid;
	logic                result_stall;
	fhp_result_t         result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned counted;
	int unsigned idle_cycles = 0;
	int unsigned holds_asked;
	bit          calm;

	fire_heat_propagation_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	fire_heat_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// no progress on either channel for too long ends the run
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("fire_heat_propagation_unit test failed");
				$finish;
			end
		end
	end

	// result side: random stall bursts, plus a long hold-off when asked
	initial begin : result_sink
		int unsigned holds_done;
		holds_done = 0;
		result_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (holds_asked != holds_done) begin
				holds_done++;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic fhp_item_t make_item(input logic op, input int r, input int c,
		input logic [7:0] near_h, input logic [7:0] far_h);
		fhp_item_t it;
		it.opcode = op;
		it.row = 8'(r);
		it.column = 8'(c);
		it.seed_near = near_h;
		it.seed_far = far_h;
		return it;
	endfunction

	task automatic offer_item(input fhp_item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		// items the unit drops do not count
		if (it.column < GRID_W && (it.opcode == OP_SEED || it.row < GRID_H)) counted++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		// a seed still in flight produces no result
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cooling(input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COOLING_ADDR;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// seed a window of columns, then rake updates over the bottom rows
	task automatic fan_flames();
		int base;
		int span;
		int depth;
		int r;
		int k;
		int c;
		bit top_down;
		logic [7:0] near_h;
		logic [7:0] far_h;
		base = $urandom_range(0, GRID_W - 1);
		span = $urandom_range(1, 6);
		for (k = 0; k < span; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				near_h = 8'($urandom);
				far_h = 8'($urandom);
			end else begin
				near_h = 8'($urandom_range(160, 254));
				far_h = 8'($urandom_range(160, 254));
			end
			offer_item(make_item(OP_SEED, $urandom, (base + k) % GRID_W, near_h, far_h));
		end
		depth = $urandom_range(1, 8);
		top_down = ($urandom_range(0, 2) == 0);
		for (k = 0; k < depth; k++) begin
			r = top_down ? GRID_H - depth + k : GRID_H - 1 - k;
			for (c = -1; c <= span; c++)
				offer_item(make_item(OP_UPDATE, r, (base + c + GRID_W) % GRID_W,
					8'($urandom), 8'($urandom)));
		end
	endtask

	initial begin : stimulus
		int ph;
		logic [7:0] cool_val;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		counted = 0;
		holds_asked = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty grid, wraparound at both edges, drops, palette bands
		offer_item(make_item(OP_UPDATE, 0, 0, 8'h00, 8'h00));
		offer_item(make_item(OP_SEED, 0, 0, 8'hFF, 8'hFF));
		offer_item(make_item(OP_SEED, 0, GRID_W - 1, 8'hFF, 8'hFF));
		offer_item(make_item(OP_SEED, 0, 1, 8'd254, 8'd160));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, 0, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, GRID_W - 1, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, 1, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, GRID_H - 2, 0, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, 0, GRID_W - 1, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, GRID_H, 5, 8'hFF, 8'hFF));
		offer_item(make_item(OP_UPDATE, 255, 255, 8'hFF, 8'hFF));
		offer_item(make_item(OP_UPDATE, 5, GRID_W, 8'h00, 8'h00));
		offer_item(make_item(OP_SEED, 0, GRID_W, 8'hFF, 8'hFF));
		offer_item(make_item(OP_SEED, 255, 255, 8'hFF, 8'hFF));
		offer_item(make_item(OP_SEED, 0, 100, 8'd70, 8'd70));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, 100, 8'h00, 8'h00));
		offer_item(make_item(OP_SEED, 0, 119, 8'd100, 8'd100));
		offer_item(make_item(OP_SEED, 0, 120, 8'd100, 8'd100));
		offer_item(make_item(OP_SEED, 0, 121, 8'd100, 8'd100));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, 120, 8'h00, 8'h00));
		offer_item(make_item(OP_UPDATE, GRID_H - 2, 120, 8'h00, 8'h00));
		offer_item(make_item(OP_SEED, 0, 120, 8'hFF, 8'hFF));
		offer_item(make_item(OP_UPDATE, GRID_H - 1, 120, 8'h00, 8'h00));

		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: cool_val = 8'd0;
					2: cool_val = 8'd255;
					5: cool_val = 8'($urandom_range(1, 20));
					default: cool_val = 8'($urandom);
				endcase
				write_cooling(cool_val);
				counted = 0;
			end
			calm = (ph == N_PHASES - 1);
			if (ph == 1) holds_asked <= holds_asked + 1;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 5) == 0)
					offer_item(make_item(1'($urandom), $urandom_range(0, 255),
						$urandom_range(0, 255), 8'($urandom), 8'($urandom)));
				else
					fan_flames();
			end
		end

		drain();
		if (fail_count == 0)
			$display("fire_heat_propagation_unit test passed");
		else
			$display("fire_heat_propagation_unit test failed");
		$finish;
	end

endmodule

### sim.f
src/fhp_pkg.sv
src/fire_heat_propagation_unit.sv
tb/fire_heat_checker.sv
tb/testbench.sv
